/* rtl/hmcik_pkg.sv */
// Shared types and constants for the chained-key hash table.
package hmcik_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CNT_W = 9;
  localparam int NB_W  = 7;

  typedef enum logic [1:0] {
    KIND_PUT    = 2'd0,
    KIND_GET    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

endpackage

/* rtl/hmcik_ram.sv */
// Generic simple dual-port RAM with registered read.
module hmcik_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/hmcik_mod.sv */
// Iterative signed key modulo bucket count, four quotient bits per cycle.
module hmcik_mod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [hmcik_pkg::KEY_W-1:0] key_i,
  input  logic [hmcik_pkg::NB_W-1:0]  n_i,
  output logic                       done_o,
  output logic [hmcik_pkg::NB_W-1:0]  rem_o
);

  localparam int STEP  = 4;
  localparam int ITERS = hmcik_pkg::KEY_W / STEP;
  localparam int CW    = $clog2(ITERS);

  logic [hmcik_pkg::KEY_W-1:0] mag_q, mag_d;
  logic [hmcik_pkg::NB_W-1:0]  rem_q, rem_d, n_q;
  logic [CW-1:0]               cnt_q;
  logic                        neg_q, busy_q, done_q;

  always_comb begin
    logic [hmcik_pkg::NB_W:0] r8;
    mag_d = mag_q;
    rem_d = rem_q;
    for (int i = 0; i < STEP; i++) begin
      r8    = {rem_d, mag_d[hmcik_pkg::KEY_W-1]};
      mag_d = {mag_d[hmcik_pkg::KEY_W-2:0], 1'b0};
      if (r8 >= {1'b0, n_q}) begin
        r8 = r8 - {1'b0, n_q};
      end
      rem_d = r8[hmcik_pkg::NB_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        neg_q  <= key_i[hmcik_pkg::KEY_W-1];
        mag_q  <= key_i[hmcik_pkg::KEY_W-1] ? (~key_i + 1'b1) : key_i;
        rem_q  <= '0;
        n_q    <= n_i;
      end else if (busy_q) begin
        mag_q <= mag_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(ITERS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  // negative keys fold to the non-negative residue
  assign rem_o  = (neg_q && rem_q != '0) ? (n_q - rem_q) : rem_q;

endmodule

/* rtl/hash_map_chained_integer_key.sv */
// Top level: chained hash table sequencer over entry and bucket memories.
//
// Input channel (in_valid_i / in_stall_o) takes one word: kind, key, value.
// kind is put, get, remove or clear. Output channel (out_valid_o /
// out_stall_i) returns one word per input: status, found, read_value and
// entry_count. cfg_we_i writes the bucket count; write it only while idle.
// Steps from the accepted word to out_valid_o: clear goes straight to
// finish. Other kinds on an empty chain run the key modulo in the
// divider, the head read, then check, act and finish. Each chain entry
// passed over adds read, compare and check; the match adds read and
// compare. Put of a new key adds new and link, with read and allocate
// first if it reuses a freed entry; remove adds the unlink and recycle steps.
// One word is in flight at a time, and the next word is taken the cycle
// after its result is loaded; the chain walk sets the pace. The result sits
// in an output register, so a new word is taken while the last result still
// waits; the sequencer holds at its last step only if a second result is
// ready before the first is taken.
// Reset empties all buckets, rebuilds the free pool, sets the bucket count
// to BUCKETS, capped at 127, and drops any pending result. No clearing
// pass is needed: bucket heads carry valid bits and the pool hands out
// never-used entries by a fill counter once the recycled list is empty.
module hash_map_chained_integer_key #(
  parameter int BUCKETS = 64,
  parameter int ENTRIES = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic signed [31:0]          key_i,
  input  logic [31:0]                 value_i,
  input  logic                        cfg_we_i,
  input  logic [hmcik_pkg::NB_W-1:0]  cfg_wdata_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic                        found_o,
  output logic [31:0]                 read_value_o,
  output logic [hmcik_pkg::CNT_W-1:0] entry_count_o
);

  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW = $clog2(ENTRIES + 1);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);
  localparam logic [hmcik_pkg::NB_W-1:0] NMAX =
    (BUCKETS > 127) ? 7'd127 : hmcik_pkg::NB_W'(BUCKETS);

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_HRD, S_HEAD, S_CHK, S_RD, S_CMP, S_ACT,
    S_ARD, S_ALLOC, S_NEW, S_LINK, S_RM1, S_RM2, S_FIN
  } state_e;

  state_e                      state_q;
  hmcik_pkg::kind_e            kind_q;
  logic [31:0]                 key_q, value_q, hval_q, rv_q;
  logic [PW-1:0]               cur_q, prev_q, hlink_q, rec_q, fresh_q, new_q, cnt_q;
  logic [BW-1:0]               bucket_q;
  logic [BUCKETS-1:0]          hvalid_q;
  logic [hmcik_pkg::NB_W-1:0]  nb_q, n_eff;
  logic                        hit_q, found_q, out_valid_q;
  logic [1:0]                  st_q;

  logic                        mod_done;
  logic [hmcik_pkg::NB_W-1:0]  mod_rem;
  logic                        in_acc;

  logic                        key_we, val_we, link_we, head_we;
  logic [EW-1:0]               val_waddr, link_waddr, link_raddr;
  logic [31:0]                 val_wdata, key_rdata, val_rdata;
  logic [PW-1:0]               link_wdata, head_wdata, link_rdata, head_rdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign n_eff = (nb_q == '0) ? 7'd1 : ((nb_q > NMAX) ? NMAX : nb_q);

  hmcik_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && kind_i != hmcik_pkg::KIND_CLEAR),
    .key_i   (key_i),
    .n_i     (n_eff),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  always_comb begin
    key_we     = (state_q == S_NEW);
    val_we     = (state_q == S_NEW) ||
                 (state_q == S_ACT && kind_q == hmcik_pkg::KIND_PUT && hit_q &&
                  hval_q != value_q);
    val_waddr  = (state_q == S_NEW) ? new_q[EW-1:0] : cur_q[EW-1:0];
    val_wdata  = value_q;
    link_we    = 1'b0;
    link_waddr = cur_q[EW-1:0];
    link_wdata = NIL;
    head_we    = 1'b0;
    head_wdata = new_q;
    unique case (state_q)
      S_NEW: begin
        link_we    = 1'b1;
        link_waddr = new_q[EW-1:0];
      end
      S_LINK: begin
        link_we    = (prev_q != NIL);
        link_waddr = prev_q[EW-1:0];
        link_wdata = new_q;
        head_we    = (prev_q == NIL);
      end
      S_RM1: begin
        link_we    = (prev_q != NIL);
        link_waddr = prev_q[EW-1:0];
        link_wdata = hlink_q;
        head_we    = (prev_q == NIL);
        head_wdata = hlink_q;
      end
      S_RM2: begin
        link_we    = 1'b1;
        link_wdata = rec_q;
      end
      default: ;
    endcase
    link_raddr = (state_q == S_ARD) ? rec_q[EW-1:0] : cur_q[EW-1:0];
  end

  hmcik_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i(clk_i), .we_i(key_we), .waddr_i(new_q[EW-1:0]), .wdata_i(key_q),
    .raddr_i(cur_q[EW-1:0]), .rdata_o(key_rdata)
  );

  hmcik_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_val_ram (
    .clk_i(clk_i), .we_i(val_we), .waddr_i(val_waddr), .wdata_i(val_wdata),
    .raddr_i(cur_q[EW-1:0]), .rdata_o(val_rdata)
  );

  hmcik_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_link_ram (
    .clk_i(clk_i), .we_i(link_we), .waddr_i(link_waddr), .wdata_i(link_wdata),
    .raddr_i(link_raddr), .rdata_o(link_rdata)
  );

  hmcik_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head_ram (
    .clk_i(clk_i), .we_i(head_we), .waddr_i(bucket_q), .wdata_i(head_wdata),
    .raddr_i(bucket_q), .rdata_o(head_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hvalid_q    <= '0;
      rec_q       <= NIL;
      fresh_q     <= '0;
      cnt_q       <= '0;
      nb_q        <= NMAX;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        nb_q <= cfg_wdata_i;
      end
      // the finish step reloads the output register itself
      if (out_valid_q && !out_stall_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q  <= hmcik_pkg::kind_e'(kind_i);
            key_q   <= key_i;
            value_q <= value_i;
            st_q    <= hmcik_pkg::ST_OK;
            found_q <= 1'b0;
            rv_q    <= '0;
            if (kind_i == hmcik_pkg::KIND_CLEAR) begin
              hvalid_q <= '0;
              rec_q    <= NIL;
              fresh_q  <= '0;
              cnt_q    <= '0;
              state_q  <= S_FIN;
            end else begin
              state_q <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            bucket_q <= BW'(mod_rem);
            state_q  <= S_HRD;
          end
        end
        S_HRD: state_q <= S_HEAD;
        S_HEAD: begin
          cur_q   <= hvalid_q[bucket_q] ? head_rdata : NIL;
          prev_q  <= NIL;
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (cur_q == NIL) begin
            hit_q   <= 1'b0;
            state_q <= S_ACT;
          end else begin
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_CMP;
        S_CMP: begin
          if (key_rdata == key_q) begin
            hit_q   <= 1'b1;
            hval_q  <= val_rdata;
            hlink_q <= link_rdata;
            state_q <= S_ACT;
          end else begin
            prev_q  <= cur_q;
            cur_q   <= link_rdata;
            state_q <= S_CHK;
          end
        end
        S_ACT: begin
          unique case (kind_q)
            hmcik_pkg::KIND_GET: begin
              if (hit_q) begin
                found_q <= 1'b1;
                rv_q    <= hval_q;
              end else begin
                st_q <= hmcik_pkg::ST_FAIL;
              end
              state_q <= S_FIN;
            end
            hmcik_pkg::KIND_PUT: begin
              if (hit_q) begin
                if (hval_q == value_q) begin
                  st_q <= hmcik_pkg::ST_FAIL;
                end
                state_q <= S_FIN;
              end else if (rec_q != NIL) begin
                state_q <= S_ARD;
              end else if (fresh_q != NIL) begin
                new_q   <= fresh_q;
                fresh_q <= fresh_q + 1'b1;
                state_q <= S_NEW;
              end else begin
                st_q    <= hmcik_pkg::ST_FULL;
                state_q <= S_FIN;
              end
            end
            hmcik_pkg::KIND_REMOVE: begin
              if (hit_q) begin
                state_q <= S_RM1;
              end else begin
                st_q    <= hmcik_pkg::ST_FAIL;
                state_q <= S_FIN;
              end
            end
            default: state_q <= S_FIN;
          endcase
        end
        S_ARD: state_q <= S_ALLOC;
        S_ALLOC: begin
          new_q   <= rec_q;
          rec_q   <= link_rdata;
          state_q <= S_NEW;
        end
        S_NEW: state_q <= S_LINK;
        S_LINK: begin
          if (prev_q == NIL) begin
            hvalid_q[bucket_q] <= 1'b1;
          end
          cnt_q   <= cnt_q + 1'b1;
          state_q <= S_FIN;
        end
        S_RM1: begin
          if (prev_q == NIL) begin
            hvalid_q[bucket_q] <= 1'b1;
          end
          state_q <= S_RM2;
        end
        S_RM2: begin
          rec_q   <= cur_q;
          cnt_q   <= cnt_q - 1'b1;
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q   <= 1'b1;
            status_o      <= st_q;
            found_o       <= found_q;
            read_value_o  <= rv_q;
            entry_count_o <= hmcik_pkg::CNT_W'(cnt_q);
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PW'(ENTRIES))
    else $error("entry count above pool size");

  a_mod_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> state_q == S_MOD)
    else $error("divider finished outside modulo step");

  a_fin_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && (!out_valid_q || !out_stall_i)) |=> out_valid_q)
    else $error("finished word not presented");

  a_no_alloc_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NEW) |-> new_q != NIL)
    else $error("allocated nil entry");

endmodule
